/* design/grk_pkg.sv */
package grk_pkg;

   // Field and register widths
   localparam int RAW_W       = 16;
   localparam int CFG_NOISE_W = 14;
   localparam int EST_W       = 24;
   localparam int VAR_W       = 32;
   localparam int VAR_FRAC    = 24;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam int RATE_FRAC_BITS_DEF = 16;

   // Measurement scaling: clamp, then times 100 / 1638 with rounding
   localparam int CLAMP_LIMIT = 1500;
   localparam int MAG_W       = 11;
   localparam int MAG100_W    = 18;
   localparam int SCALE_NUM   = 100;
   localparam int SCALE_DEN   = 1638;
   localparam int SCALE_ROUND = 819;
   // Integer bits of the scaled magnitude (1500 * 100 / 1638 < 128)
   localparam int SCALE_INT_W = 7;

   // Noise terms in thousandths to Q8.24
   localparam int MILLI       = 1000;
   localparam int MILLI_ROUND = 500;
   localparam int NOISE_DW    = CFG_NOISE_W + VAR_FRAC;
   localparam int QN_W        = 29;
   localparam int PM_W        = VAR_W + 1;
   localparam int DEN_W       = PM_W + 1;
   localparam int DVA_W       = 11;
   localparam int KG_W        = VAR_FRAC + 1;
   localparam int KG_ONE      = 1 << VAR_FRAC;
   localparam int DIFF_W      = EST_W + 1;

   localparam int EST_MAX = (2 ** (EST_W - 1)) - 1;
   localparam logic signed [EST_W-1:0] EST_HI = {1'b0, {(EST_W - 1){1'b1}}};
   localparam logic signed [EST_W-1:0] EST_LO = {1'b1, {(EST_W - 1){1'b0}}};

   // Register reset values
   localparam logic signed [RAW_W-1:0]   Z_OFFSET_RST = RAW_W'(-2);
   localparam logic [CFG_NOISE_W-1:0]    Q_NOISE_RST  = CFG_NOISE_W'(80);
   localparam logic [CFG_NOISE_W-1:0]    R_NOISE_RST  = CFG_NOISE_W'(320);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_Z_OFFSET      = 2'd0,
      CSR_PROCESS_NOISE = 2'd1,
      CSR_MEASURE_NOISE = 2'd2
   } csr_index_type;

endpackage

/* design/grk_stream_if.sv */
interface grk_req_if import grk_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_rate;
   logic                    read_ok;

   modport source (output valid, output raw_rate, output read_ok, input ready);
   modport sink   (input valid, input raw_rate, input read_ok, output ready);
endinterface

interface grk_rsp_if import grk_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [EST_W-1:0] filtered_rate;
   logic                    rate_valid;

   modport source (output valid, output filtered_rate, output rate_valid, input ready);
   modport sink   (input valid, input filtered_rate, input rate_valid, output ready);
endinterface

/* design/grk_serdiv.sv */
// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
module grk_serdiv import grk_pkg::*; #(
   parameter int DW  = NOISE_DW,
   parameter int DVW = DEN_W,
   parameter int QW  = QN_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DW-1:0]              dividend,
   input  logic [DVW-1:0]             divisor,
   input  logic [DVW-1:0]             rem_init,
   input  logic                       quo_init,
   input  logic [$clog2(DW+1)-1:0]    count,
   output logic                       busy,
   output logic [QW-1:0]              quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0]  dvd_ff, dvd_in;
   logic [DVW-1:0] dvs_ff, dvs_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;

   logic [DVW:0]   trial;
   logic [DVW:0]   trial_sub;
   logic           fits;

   assign trial     = {rem_ff, dvd_ff[DW-1]};
   assign fits      = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = rem_init;
         quo_in  = QW'(quo_init);
         cnt_in  = count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = fits ? trial_sub[DVW-1:0] : trial[DVW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && dvs_ff != '0) |-> (rem_ff < dvs_ff))
      else $error("partial remainder reached the divisor");

   a_count_ends_run: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CW'(1) && !start) |=> !busy_ff)
      else $error("divider ran past its bit count");

endmodule

/* design/grk_sermul.sv */
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module grk_sermul import grk_pkg::*; #(
   parameter int AW = PM_W,
   parameter int BW = KG_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             busy,
   output logic [AW+BW-1:0] product
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0]    a_ff, a_in;
   logic [AW+BW-1:0] p_ff, p_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [AW:0]      upper;

   assign upper = {1'b0, p_ff[AW+BW-1:BW]} + (p_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      a_in    = a_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a;
         p_in    = {{AW{1'b0}}, b};
         cnt_in  = CW'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {upper, p_ff[BW-1:1]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign busy    = busy_ff;
   assign product = p_ff;

endmodule

/* design/gyro_rate_kalman_filter_core.sv */
// Scalar Kalman filter for the z-axis gyro rate. Each request word carries one raw signed
// sample and a read-ok flag; each produces exactly one response word. On a good read the
// sample has the z_offset bias removed, is clamped to +/-1500 counts, scaled to degrees per
// second (divide by 16.38) with RATE_FRAC_BITS fraction bits, and fed into a one-state
// Kalman update; the response carries the new estimate with rate_valid set. On a failed
// read the filter state is left alone and the response carries the current estimate with
// rate_valid clear. Q and R are written in thousandths through the CSR port; the user must
// write them only while the block is idle, as the block itself does not enforce this. Items
// are handled one at a time: a good sample passes through the bit-serial scaling divider
// and then the 25-step serial multipliers; the first good sample after reset or after a
// write to either noise register first converts Q and R to Q8.24 on the same dividers. A
// new request is taken while the previous response still waits in the output register.
module gyro_rate_kalman_filter_core import grk_pkg::*; #(
   parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   grk_req_if.sink                req_chan,
   grk_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Scaled measurement dividend and the shared divider/multiplier sizes
   localparam int ZW        = MAG100_W + RATE_FRAC_BITS;
   localparam int DW_A      = (ZW > NOISE_DW) ? ZW : NOISE_DW;
   localparam int QW_A      = (RATE_FRAC_BITS + SCALE_INT_W > QN_W) ?
                              RATE_FRAC_BITS + SCALE_INT_W : QN_W;
   localparam int CW_A      = $clog2(DW_A + 1);
   localparam int CW_B      = $clog2(NOISE_DW + 1);
   localparam int M1_W      = DIFF_W + KG_W;
   localparam int M2_W      = PM_W + KG_W;
   localparam int M1R_W     = M1_W - VAR_FRAC;
   localparam int M2R_W     = M2_W - VAR_FRAC;
   localparam int EST_SUM_W = M1R_W + 1;

   localparam logic signed [RAW_W:0] CLAMP_HI = (RAW_W + 1)'(CLAMP_LIMIT);
   localparam logic signed [RAW_W:0] CLAMP_LO = -CLAMP_HI;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_NOISE,
      S_START,
      S_KSTART,
      S_DIV,
      S_MSTART,
      S_MUL,
      S_UPD,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic signed [RAW_W-1:0]  zoff_ff, zoff_in;
   logic [CFG_NOISE_W-1:0]   qn_ff, qn_in;
   logic [CFG_NOISE_W-1:0]   rn_ff, rn_in;
   logic                     stale_ff, stale_in;

   // Filter state
   logic signed [EST_W-1:0]  est_ff, est_in;
   logic [VAR_W-1:0]         var_ff, var_in;

   // Per-item working registers
   logic signed [RAW_W-1:0]  raw_ff, raw_in;
   logic                     ok_ff, ok_in;
   logic                     neg_ff, neg_in;
   logic [ZW-1:0]            zdvd_ff, zdvd_in;
   logic [QN_W-1:0]          q_ff, q_in;
   logic [QN_W-1:0]          r_ff, r_in;
   logic [PM_W-1:0]          pmid_ff, pmid_in;
   logic                     den_zero_ff, den_zero_in;
   logic signed [EST_W-1:0]  z_ff, z_in;
   logic [KG_W-1:0]          kg_ff, kg_in;
   logic                     dneg_ff, dneg_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [EST_W-1:0]  rsp_rate_ff, rsp_rate_in;
   logic                     rsp_flag_ff, rsp_flag_in;

   // Datapath
   logic signed [RAW_W:0]    c_diff;
   logic                     c_neg;
   logic [MAG_W-1:0]         c_mag;
   logic [MAG100_W-1:0]      mag100;
   logic [ZW-1:0]            z_dvd;
   logic [NOISE_DW-1:0]      q_dvd;
   logic [NOISE_DW-1:0]      r_dvd;
   logic [DEN_W-1:0]         den;
   logic                     r_zero;
   logic signed [EST_W-1:0]  z_sat;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_mag;
   logic [M1R_W-1:0]         m1_rnd;
   logic signed [EST_SUM_W-1:0] est_sum;
   logic signed [EST_W-1:0]  est_sat;
   logic [M2R_W-1:0]         var_rnd;
   logic [VAR_W-1:0]         var_sat;

   // Serial units
   logic                     diva_start, diva_busy;
   logic [DW_A-1:0]          diva_dvd;
   logic [DVA_W-1:0]         diva_dvs;
   logic [QW_A-1:0]          diva_quo;
   logic                     divb_start, divb_busy;
   logic [NOISE_DW-1:0]      divb_dvd;
   logic [DEN_W-1:0]         divb_dvs;
   logic [DEN_W-1:0]         divb_rem;
   logic                     divb_qinit;
   logic [CW_B-1:0]          divb_cnt;
   logic [QN_W-1:0]          divb_quo;
   logic                     mul_start;
   logic                     mul1_busy, mul2_busy;
   logic [M1_W-1:0]          mul1_p;
   logic [M2_W-1:0]          mul2_p;

   // Bias removal and clamp, formed one bit wider so the difference never wraps
   assign c_diff = $signed({raw_ff[RAW_W-1], raw_ff}) - $signed({zoff_ff[RAW_W-1], zoff_ff});
   assign c_neg  = c_diff[RAW_W];

   always_comb begin
      if (c_diff > CLAMP_HI) begin
         c_mag = MAG_W'(CLAMP_LIMIT);
      end else if (c_diff < CLAMP_LO) begin
         c_mag = MAG_W'(CLAMP_LIMIT);
      end else if (c_neg) begin
         c_mag = MAG_W'(-c_diff);
      end else begin
         c_mag = c_diff[MAG_W-1:0];
      end
   end

   // round(|c| * 100 * 2^F / 1638): numerator plus half the divisor, then divide
   assign mag100 = MAG100_W'(c_mag) * MAG100_W'(SCALE_NUM);
   assign z_dvd  = (ZW'(mag100) << RATE_FRAC_BITS) + ZW'(SCALE_ROUND);

   // Q and R to Q8.24, rounded half up
   assign q_dvd = (NOISE_DW'(qn_ff) << VAR_FRAC) + NOISE_DW'(MILLI_ROUND);
   assign r_dvd = (NOISE_DW'(rn_ff) << VAR_FRAC) + NOISE_DW'(MILLI_ROUND);

   // Gain denominator; with R zero the gain is exactly one unless the denominator is zero
   assign den    = DEN_W'(pmid_ff) + DEN_W'(r_ff);
   assign r_zero = (r_ff == '0);

   // Apply the sign and saturate the measurement to the estimate range
   always_comb begin
      if (!neg_ff) begin
         z_sat = (diva_quo > QW_A'(EST_MAX)) ? EST_HI : diva_quo[EST_W-1:0];
      end else begin
         z_sat = (diva_quo > QW_A'(EST_MAX + 1)) ? EST_LO : -$signed(diva_quo[EST_W-1:0]);
      end
   end

   // Innovation, magnitude and sign kept apart for the unsigned multiplier
   assign diff     = $signed({z_ff[EST_W-1], z_ff}) - $signed({est_ff[EST_W-1], est_ff});
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

   // Round half away from zero on the magnitude, then restore the sign
   assign m1_rnd  = mul1_p[M1_W-1:VAR_FRAC] + M1R_W'(mul1_p[VAR_FRAC-1]);
   assign est_sum = EST_SUM_W'(est_ff) +
                    (dneg_ff ? -EST_SUM_W'(m1_rnd) : EST_SUM_W'(m1_rnd));

   always_comb begin
      if (est_sum > EST_SUM_W'(EST_HI)) begin
         est_sat = EST_HI;
      end else if (est_sum < EST_SUM_W'(EST_LO)) begin
         est_sat = EST_LO;
      end else begin
         est_sat = est_sum[EST_W-1:0];
      end
   end

   // (1 - k) * p_mid, rounded half up and held to 32 bits
   assign var_rnd = mul2_p[M2_W-1:VAR_FRAC] + M2R_W'(mul2_p[VAR_FRAC-1]);
   assign var_sat = (|var_rnd[M2R_W-1:VAR_W]) ? '1 : var_rnd[VAR_W-1:0];

   // Divider A: Q conversion, then the measurement scaling
   assign diva_start = ((state_ff == S_PREP) && stale_ff) || (state_ff == S_START);
   assign diva_dvd   = (state_ff == S_PREP) ? DW_A'(q_dvd) : DW_A'(zdvd_ff);
   assign diva_dvs   = (state_ff == S_PREP) ? DVA_W'(MILLI) : DVA_W'(SCALE_DEN);

   // Divider B: R conversion, then the gain
   assign divb_start = ((state_ff == S_PREP) && stale_ff) || (state_ff == S_KSTART);
   assign divb_dvd   = (state_ff == S_PREP) ? r_dvd : '0;
   assign divb_dvs   = (state_ff == S_PREP) ? DEN_W'(MILLI) : den;
   assign divb_rem   = ((state_ff == S_PREP) || r_zero) ? '0 : DEN_W'(pmid_ff);
   assign divb_qinit = (state_ff != S_PREP) && r_zero;
   assign divb_cnt   = (state_ff == S_PREP) ? CW_B'(NOISE_DW) : CW_B'(VAR_FRAC);

   assign mul_start = (state_ff == S_MSTART);

   grk_serdiv #(
      .DW  (DW_A),
      .DVW (DVA_W),
      .QW  (QW_A)
   ) u_div_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (diva_start),
      .dividend (diva_dvd),
      .divisor  (diva_dvs),
      .rem_init ('0),
      .quo_init (1'b0),
      .count    (CW_A'(DW_A)),
      .busy     (diva_busy),
      .quotient (diva_quo)
   );

   grk_serdiv #(
      .DW  (NOISE_DW),
      .DVW (DEN_W),
      .QW  (QN_W)
   ) u_div_gain (
      .clock    (clock),
      .reset    (reset),
      .start    (divb_start),
      .dividend (divb_dvd),
      .divisor  (divb_dvs),
      .rem_init (divb_rem),
      .quo_init (divb_qinit),
      .count    (divb_cnt),
      .busy     (divb_busy),
      .quotient (divb_quo)
   );

   grk_sermul #(
      .AW (DIFF_W),
      .BW (KG_W)
   ) u_mul_est (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (diff_mag),
      .b       (kg_ff),
      .busy    (mul1_busy),
      .product (mul1_p)
   );

   grk_sermul #(
      .AW (PM_W),
      .BW (KG_W)
   ) u_mul_var (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (pmid_ff),
      .b       (KG_W'(KG_ONE) - kg_ff),
      .busy    (mul2_busy),
      .product (mul2_p)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      zoff_in      = zoff_ff;
      qn_in        = qn_ff;
      rn_in        = rn_ff;
      stale_in     = stale_ff;
      est_in       = est_ff;
      var_in       = var_ff;
      raw_in       = raw_ff;
      ok_in        = ok_ff;
      neg_in       = neg_ff;
      zdvd_in      = zdvd_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      pmid_in      = pmid_ff;
      den_zero_in  = den_zero_ff;
      z_in         = z_ff;
      kg_in        = kg_ff;
      dneg_in      = dneg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_flag_in  = rsp_flag_ff;

      // Drop the response word once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               raw_in   = req_chan.raw_rate;
               ok_in    = req_chan.read_ok;
               state_in = req_chan.read_ok ? S_PREP : S_DONE;
            end
         end
         S_PREP: begin
            neg_in   = c_neg;
            zdvd_in  = z_dvd;
            state_in = stale_ff ? S_NOISE : S_START;
         end
         S_NOISE: begin
            if (!diva_busy && !divb_busy) begin
               q_in     = QN_W'(diva_quo);
               r_in     = divb_quo;
               stale_in = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            pmid_in  = PM_W'(var_ff) + PM_W'(q_ff);
            state_in = S_KSTART;
         end
         S_KSTART: begin
            den_zero_in = (den == '0);
            state_in    = S_DIV;
         end
         S_DIV: begin
            if (!diva_busy && !divb_busy) begin
               z_in     = z_sat;
               kg_in    = den_zero_ff ? '0 : divb_quo[KG_W-1:0];
               state_in = S_MSTART;
            end
         end
         S_MSTART: begin
            dneg_in  = diff[DIFF_W-1];
            state_in = S_MUL;
         end
         S_MUL: begin
            if (!mul1_busy && !mul2_busy) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            est_in   = est_sat;
            var_in   = var_sat;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = est_ff;
               rsp_flag_in  = ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes; a new Q or R forces a fresh conversion on the next good sample
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_Z_OFFSET: begin
               zoff_in = csr_wdata;
            end
            CSR_PROCESS_NOISE: begin
               qn_in    = csr_wdata[CFG_NOISE_W-1:0];
               stale_in = 1'b1;
            end
            CSR_MEASURE_NOISE: begin
               rn_in    = csr_wdata[CFG_NOISE_W-1:0];
               stale_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         zoff_ff      <= Z_OFFSET_RST;
         qn_ff        <= Q_NOISE_RST;
         rn_ff        <= R_NOISE_RST;
         stale_ff     <= 1'b1;
         est_ff       <= '0;
         var_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zoff_ff      <= zoff_in;
         qn_ff        <= qn_in;
         rn_ff        <= rn_in;
         stale_ff     <= stale_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff      <= raw_in;
      ok_ff       <= ok_in;
      neg_ff      <= neg_in;
      zdvd_ff     <= zdvd_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      pmid_ff     <= pmid_in;
      den_zero_ff <= den_zero_in;
      z_ff        <= z_in;
      kg_ff       <= kg_in;
      dneg_ff     <= dneg_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.filtered_rate = rsp_rate_ff;
   assign rsp_chan.rate_valid    = rsp_flag_ff;

   a_gain_at_most_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MSTART) |-> (kg_ff <= KG_W'(KG_ONE)))
      else $error("Kalman gain above one");

   a_state_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_UPD) |=> ($stable(est_ff) && $stable(var_ff)))
      else $error("filter state moved outside the update step");

   a_units_idle_at_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (!diva_busy && !divb_busy && !mul1_busy && !mul2_busy))
      else $error("update taken while a serial unit still runs");

endmodule

/* tb/tb_gyro_rate_kalman_filter_core.sv */
`timescale 1ns / 100ps

module tb_gyro_rate_kalman_filter_core import grk_pkg::*; ();

   localparam int FRAC_BITS         = RATE_FRAC_BITS_DEF;
   localparam int RAND_WORDS        = 1700;
   localparam int WORDS_PER_SETTING = 140;
   localparam int DRAIN_CYCLES      = 120;
   localparam int NUM_ROWS          = 24;
   localparam int GOOD_READ_PCT     = 85;
   // Full-scale measurement: 1500 counts / 16.38 in Q.16, rounded
   localparam logic signed [EST_W-1:0] FULL_SCALE = 24'sd6001465;

   typedef enum logic {ROW_WORD, ROW_SETTING} row_kind_type;

   // One row of the directed table: either a request word or a full register setting
   typedef struct {
      row_kind_type              kind;
      logic signed [RAW_W-1:0]   raw;
      logic                      ok;
      logic signed [RAW_W-1:0]   bias;
      logic [CFG_NOISE_W-1:0]    q_milli;
      logic [CFG_NOISE_W-1:0]    r_milli;
      bit                        typed;
      logic signed [EST_W-1:0]   rate;
      logic                      rate_ok;
   } stim_row_type;

   typedef struct {
      logic signed [EST_W-1:0] rate;
      logic                    rate_ok;
   } rate_word_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   grk_req_if req_if ();
   grk_rsp_if rsp_if ();

   gyro_rate_kalman_filter_core #(
      .RATE_FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Filter state and register copies held alongside the block
   longint                   est_model  = 0;
   logic [63:0]              var_model  = '0;
   logic signed [RAW_W-1:0]  bias_cfg   = Z_OFFSET_RST;
   logic [CFG_NOISE_W-1:0]   q_cfg      = Q_NOISE_RST;
   logic [CFG_NOISE_W-1:0]   r_cfg      = R_NOISE_RST;

   rate_word_type  pending_rates[$];
   int             mismatches    = 0;
   int             send_idle_pct = 32;
   int             recv_idle_pct = 79;
   stim_row_type   stim_tab [NUM_ROWS];

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bound the run; a hang on either channel ends here
   initial begin
      #5_000_000;
      $display("** gyro_rate_kalman_filter_core: FAILED **");
      $finish;
   end

   function automatic longint sat_est(input longint v);
      if (v > longint'(EST_MAX)) return longint'(EST_MAX);
      if (v < -longint'(EST_MAX) - 1) return -longint'(EST_MAX) - 1;
      return v;
   endfunction

   // Advance the filter by one sample and return the word the block should send back.
   // A failed read leaves the state alone and echoes the current estimate.
   function automatic rate_word_type filter_rate(input logic signed [RAW_W-1:0] raw,
                                                 input logic ok);
      longint        corr;
      longint        meas;
      longint        diff;
      logic [63:0]   mag;
      logic [63:0]   q8;
      logic [63:0]   r8;
      logic [63:0]   p_mid;
      logic [63:0]   den;
      logic [63:0]   gain;
      logic [63:0]   prod;
      logic [63:0]   p_new;
      rate_word_type w;
      if (ok) begin
         // Remove the bias at full width so a large difference never wraps, then clamp
         corr = longint'(raw) - longint'(bias_cfg);
         if (corr > CLAMP_LIMIT) corr = CLAMP_LIMIT;
         if (corr < -CLAMP_LIMIT) corr = -CLAMP_LIMIT;
         // Scale by 100 / 1638, rounding the magnitude half away from zero
         mag  = (corr < 0) ? 64'(-corr) : 64'(corr);
         mag  = (((mag * 64'd100) << FRAC_BITS) + 64'd819) / 64'd1638;
         meas = sat_est((corr < 0) ? -longint'(mag) : longint'(mag));
         // Noise terms from thousandths to Q8.24, ties up
         q8    = ((64'(q_cfg) << VAR_FRAC) + 64'd500) / 64'd1000;
         r8    = ((64'(r_cfg) << VAR_FRAC) + 64'd500) / 64'd1000;
         p_mid = var_model + q8;
         den   = p_mid + r8;
         // Zero denominator: hold the gain at zero
         gain  = (den == 64'd0) ? 64'd0 : (p_mid << VAR_FRAC) / den;
         diff  = meas - est_model;
         prod  = (((diff < 0) ? 64'(-diff) : 64'(diff)) * gain
                  + (64'd1 << (VAR_FRAC - 1))) >> VAR_FRAC;
         est_model = sat_est(est_model + ((diff < 0) ? -longint'(prod) : longint'(prod)));
         p_new = (p_mid * ((64'd1 << VAR_FRAC) - gain) + (64'd1 << (VAR_FRAC - 1))) >> VAR_FRAC;
         var_model = (p_new > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p_new;
      end
      w.rate    = EST_W'(est_model);
      w.rate_ok = ok;
      return w;
   endfunction

   function automatic logic [CFG_NOISE_W-1:0] pick_noise();
      case ($urandom_range(5))
         0:       return '0;
         1:       return CFG_NOISE_W'(10000);
         default: return CFG_NOISE_W'($urandom_range(10000));
      endcase
   endfunction

   // Most samples land near the bias so the clamp is reached only now and then
   function automatic logic signed [RAW_W-1:0] next_raw();
      case ($urandom_range(9))
         0:       return RAW_W'($urandom);
         1:       return ($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000;
         default: return bias_cfg + RAW_W'($urandom_range(3200)) - 16'sd1600;
      endcase
   endfunction

   // Present one request word, idling at random first, and log what it should return.
   // Valid is left high on return so that back-to-back words need no second assignment.
   task automatic send_word(input logic signed [RAW_W-1:0] raw, input logic ok,
                            input bit typed, input rate_word_type typed_word);
      rate_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.raw_rate <= raw;
      req_if.read_ok  <= ok;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = filter_rate(raw, ok);
      if (typed) begin
         pending_rates.push_back(typed_word);
      end else begin
         pending_rates.push_back(predicted);
      end
   endtask

   // Drain the block, then write all three registers on consecutive edges
   task automatic apply_setting(input logic signed [RAW_W-1:0] bias,
                                input logic [CFG_NOISE_W-1:0] q_milli,
                                input logic [CFG_NOISE_W-1:0] r_milli);
      req_if.valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_Z_OFFSET;
      csr_wdata <= bias;
      @(posedge clock);
      csr_index <= CSR_PROCESS_NOISE;
      csr_wdata <= CSR_DATA_W'(q_milli);
      @(posedge clock);
      csr_index <= CSR_MEASURE_NOISE;
      csr_wdata <= CSR_DATA_W'(r_milli);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bias_cfg = bias;
      q_cfg    = q_milli;
      r_cfg    = r_milli;
   endtask

   // Response side: check each accepted word against the oldest expectation,
   // then decide whether to stall for the next cycle
   initial begin
      rate_word_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_rates.size() == 0) begin
               $display("%0t: response word with none expected: rate %0d valid %0b",
                        $time, rsp_if.filtered_rate, rsp_if.rate_valid);
               mismatches++;
            end else begin
               want = pending_rates.pop_front();
               if (rsp_if.filtered_rate !== want.rate) begin
                  $display("%0t: filtered_rate expected %0d actual %0d",
                           $time, want.rate, rsp_if.filtered_rate);
                  mismatches++;
               end
               if (rsp_if.rate_valid !== want.rate_ok) begin
                  $display("%0t: rate_valid expected %0b actual %0b",
                           $time, want.rate_ok, rsp_if.rate_valid);
                  mismatches++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Request side and register writes
   initial begin
      rate_word_type            typed_word;
      rate_word_type            no_word;
      logic signed [RAW_W-1:0]  bias;
      int                       setting_no;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.raw_rate <= '0;
      req_if.read_ok  <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_Z_OFFSET;
      csr_wdata       <= '0;
      no_word.rate    = '0;
      no_word.rate_ok = 1'b0;
      setting_no      = 0;

      // Directed table. Typed rows can be read off directly: state straight out of reset,
      // full gain (R of zero) snapping the estimate onto the clamped measurement, and a
      // zero denominator (Q and R zero with zero variance) holding it where it is.
      stim_tab = '{
         // failed read out of reset: estimate still zero
         '{ROW_WORD,    16'sd0,     1'b0, 16'sd0, 14'd0, 14'd0, 1'b1, 24'sd0, 1'b0},
         // first good reads run on the reset register values
         '{ROW_WORD,    16'sd100,   1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sh7FFF,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sh8000,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         // failed read carries the current estimate
         '{ROW_WORD,    16'sd0,     1'b0, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         // just over and exactly on the clamp once the bias of -2 is removed
         '{ROW_WORD,    16'sd1502,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    -16'sd1502, 1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_SETTING, 16'sd0,     1'b0, 16'sh7FFF, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         // bias difference of -65535 must not wrap; full gain, variance collapses
         '{ROW_WORD,    16'sh8000,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b1, -FULL_SCALE, 1'b1},
         // zero denominator: estimate held
         '{ROW_WORD,    16'sd5,     1'b1, 16'sd0, 14'd0, 14'd0, 1'b1, -FULL_SCALE, 1'b1},
         '{ROW_SETTING, 16'sd0,     1'b0, 16'sh8000, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         // bias difference of +65535, still zero denominator
         '{ROW_WORD,    16'sh7FFF,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b1, -FULL_SCALE, 1'b1},
         '{ROW_SETTING, 16'sd0,     1'b0, 16'sh8000, 14'd10000, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sh7FFF,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b1, FULL_SCALE, 1'b1},
         '{ROW_WORD,    16'sd0,     1'b0, 16'sd0, 14'd0, 14'd0, 1'b1, FULL_SCALE, 1'b0},
         '{ROW_SETTING, 16'sd0,     1'b0, 16'sd0, 14'd10000, 14'd10000, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sh5555,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'shAAAA,  1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sd1,     1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    -16'sd1,    1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_SETTING, 16'sd0,     1'b0, 16'sd3, 14'd1, 14'd9999, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sd3,     1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    -16'sd1497, 1'b1, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0},
         '{ROW_WORD,    16'sh7FFF,  1'b0, 16'sd0, 14'd0, 14'd0, 1'b0, 24'sd0, 1'b0}
      };

      // Hold reset once, at the start of the run
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_tab[i]) begin
         if (stim_tab[i].kind == ROW_SETTING) begin
            apply_setting(stim_tab[i].bias, stim_tab[i].q_milli, stim_tab[i].r_milli);
         end else begin
            typed_word.rate    = stim_tab[i].rate;
            typed_word.rate_ok = stim_tab[i].rate_ok;
            send_word(stim_tab[i].raw, stim_tab[i].ok, stim_tab[i].typed, typed_word);
         end
      end

      // Random words: sender idles lightly and receiver heavily, then the reverse,
      // then neither. Move to a fresh register setting every so often.
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (n == RAND_WORDS / 3) begin
            send_idle_pct = 79;
            recv_idle_pct = 32;
         end
         if (n == 2 * RAND_WORDS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % WORDS_PER_SETTING == 0) begin
            setting_no++;
            if (setting_no == 4) begin
               // revisit the power-on values
               apply_setting(Z_OFFSET_RST, Q_NOISE_RST, R_NOISE_RST);
            end else begin
               bias = ($urandom_range(3) == 0) ? RAW_W'($urandom)
                                               : RAW_W'($urandom_range(40)) - 16'sd20;
               apply_setting(bias, pick_noise(), pick_noise());
            end
         end
         send_word(next_raw(), $urandom_range(99) < GOOD_READ_PCT, 1'b0, no_word);
      end

      // Drop valid, wait for every response, then let the block settle
      req_if.valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("** gyro_rate_kalman_filter_core: PASSED **");
      end else begin
         $display("** gyro_rate_kalman_filter_core: FAILED **");
      end
      $finish;
   end

endmodule
